### rtl/fac_pkg.sv
// ----------------------------------------------------------------------------
// fac_pkg
// shared types and constants for the frame address / checksum filter
// ----------------------------------------------------------------------------
package fac_pkg;

  localparam int unsigned CfgAddrW = 4;
  localparam int unsigned CfgDataW = 32;

  // register index, taken from paddr[3:2]
  typedef enum logic [1:0] {
    REG_CLUSTER_ID = 2'd0,
    REG_INNER_NUM  = 2'd1,
    REG_PHYS_ADDR  = 2'd2,
    REG_BCAST_VAL  = 2'd3
  } reg_idx_t;

  localparam logic [7:0] BcastResetVal = 8'hFF;
  localparam logic [7:0] CheckBase     = 8'hFF;

  typedef struct packed {
    logic [7:0]  own_cluster_id;
    logic [7:0]  own_inner_number;
    logic [15:0] own_physical_address;
    logic [7:0]  broadcast_value;
  } fac_cfg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
  } fac_item_t;

endpackage

### rtl/fac_cfg_regs.sv
// ----------------------------------------------------------------------------
// fac_cfg_regs
// apb register file holding node addresses and the broadcast marker
// ----------------------------------------------------------------------------
module fac_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fac_pkg::CfgAddrW-1:0]  paddr,
  input  logic [fac_pkg::CfgDataW-1:0]  pwdata,
  output logic [fac_pkg::CfgDataW-1:0]  prdata,
  output logic                          pready,
  output fac_pkg::fac_cfg_t             cfg
);
  import fac_pkg::*;

  fac_cfg_t cfg_r;
  fac_cfg_t cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite && pready;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_CLUSTER_ID: cfg_nxt.own_cluster_id       = pwdata[7:0];
        REG_INNER_NUM:  cfg_nxt.own_inner_number     = pwdata[7:0];
        REG_PHYS_ADDR:  cfg_nxt.own_physical_address = pwdata[15:0];
        REG_BCAST_VAL:  cfg_nxt.broadcast_value      = pwdata[7:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_CLUSTER_ID: prdata = {24'd0, cfg_r.own_cluster_id};
      REG_INNER_NUM:  prdata = {24'd0, cfg_r.own_inner_number};
      REG_PHYS_ADDR:  prdata = {16'd0, cfg_r.own_physical_address};
      REG_BCAST_VAL:  prdata = {24'd0, cfg_r.broadcast_value};
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.own_cluster_id       <= 8'd0;
      cfg_r.own_inner_number     <= 8'd0;
      cfg_r.own_physical_address <= 16'd0;
      cfg_r.broadcast_value      <= BcastResetVal;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

### rtl/fac_in_stage.sv
// ----------------------------------------------------------------------------
// fac_in_stage
// input register stage in front of the frame tracker
// ----------------------------------------------------------------------------
module fac_in_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  fac_pkg::fac_item_t in_item,
  output logic               s1_valid,
  input  logic               s1_take,
  output fac_pkg::fac_item_t s1_item
);
  import fac_pkg::*;

  logic      valid_r;
  logic      valid_nxt;
  fac_item_t item_r;

  assign in_ready  = !valid_r || s1_take;
  assign s1_valid  = valid_r;
  assign s1_item   = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_ready) begin
      valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  // a held beat is never dropped
  assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && !s1_take) |=> valid_r)
    else $error("input stage lost a held beat");

endmodule

### rtl/fac_core.sv
// ----------------------------------------------------------------------------
// fac_core
// frame position, running sum, address capture and the accept decision
// ----------------------------------------------------------------------------
module fac_core #(
  parameter int unsigned FRAME_LENGTH = 12
) (
  input  logic               clk,
  input  logic               rst_n,
  input  fac_pkg::fac_cfg_t  cfg,
  input  logic               s1_valid,
  output logic               s1_take,
  input  fac_pkg::fac_item_t s1_item,
  output logic               res_valid,
  input  logic               res_ready,
  output logic               res_accept
);
  import fac_pkg::*;

  localparam int unsigned PosW = $clog2(FRAME_LENGTH);
  localparam logic [PosW-1:0] LastPos = PosW'(FRAME_LENGTH - 1);

  logic [PosW-1:0] pos_r,   pos_nxt;
  logic [7:0]      sum_r,   sum_nxt;
  logic            nz_r,    nz_nxt;
  logic [7:0]      ahi_r,   ahi_nxt;
  logic [7:0]      alo_r,   alo_nxt;
  logic            ovld_r,  ovld_nxt;
  logic            oacc_r,  oacc_nxt;

  logic [PosW-1:0] pos_eff;
  logic            go;
  logic            is_last;
  logic            addr_ok;
  logic [7:0]      check;

  assign go      = s1_valid && (!ovld_r || res_ready);
  assign s1_take = go;
  assign pos_eff = s1_item.frame_start ? '0 : pos_r;
  assign is_last = (pos_eff >= LastPos);
  assign check   = CheckBase - sum_r;

  assign addr_ok =
      (ahi_r == cfg.own_cluster_id && alo_r == cfg.own_inner_number) ||
      (ahi_r == cfg.broadcast_value && alo_r == cfg.broadcast_value) ||
      ({ahi_r, alo_r} == cfg.own_physical_address) ||
      (ahi_r == cfg.own_cluster_id && alo_r == cfg.broadcast_value);

  always_comb begin
    pos_nxt  = pos_r;
    sum_nxt  = sum_r;
    nz_nxt   = nz_r;
    ahi_nxt  = ahi_r;
    alo_nxt  = alo_r;
    ovld_nxt = ovld_r && !res_ready;
    oacc_nxt = oacc_r;
    if (go) begin
      if (is_last) begin
        // checksum byte: decide and wrap
        ovld_nxt = 1'b1;
        oacc_nxt = nz_r && addr_ok && (check == s1_item.data_byte);
        pos_nxt  = '0;
        sum_nxt  = 8'd0;
      end else begin
        if (pos_eff == '0) begin
          nz_nxt  = (s1_item.data_byte != 8'd0);
          ahi_nxt = 8'd0;
          alo_nxt = 8'd0;
          sum_nxt = s1_item.data_byte;
        end else begin
          if (pos_eff == PosW'(2)) ahi_nxt = s1_item.data_byte;
          if (pos_eff == PosW'(3)) alo_nxt = s1_item.data_byte;
          sum_nxt = sum_r + s1_item.data_byte;
        end
        pos_nxt = pos_eff + PosW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      sum_r  <= 8'd0;
      nz_r   <= 1'b0;
      ahi_r  <= 8'd0;
      alo_r  <= 8'd0;
      ovld_r <= 1'b0;
      oacc_r <= 1'b0;
    end else begin
      pos_r  <= pos_nxt;
      sum_r  <= sum_nxt;
      nz_r   <= nz_nxt;
      ahi_r  <= ahi_nxt;
      alo_r  <= alo_nxt;
      ovld_r <= ovld_nxt;
      oacc_r <= oacc_nxt;
    end
  end

  assign res_valid  = ovld_r;
  assign res_accept = oacc_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= LastPos)
    else $error("byte position past end of frame");

  assert property (@(posedge clk) disable iff (!rst_n)
    (go && is_last) |=> (pos_r == '0 && sum_r == 8'd0 && ovld_r))
    else $error("frame end did not wrap or post a result");

  assert property (@(posedge clk) disable iff (!rst_n)
    (go && !is_last && !(ovld_r && !res_ready)) |=> !ovld_r)
    else $error("result posted for a non-final byte");

endmodule

### rtl/frame_address_checksum_filter_top.sv
// ----------------------------------------------------------------------------
// frame_address_checksum_filter_top
// order: a byte goes into the input register on its accepting edge; the
//   decision for a frame's last byte then goes into the result register
// throughput: one byte per cycle while the result register is not stalled,
//   limited by the single position/sum update
// reset: rst_n low clears position, sum, captured address and both stages;
//   registers return to zero, broadcast marker to 0xff
// ----------------------------------------------------------------------------
module frame_address_checksum_filter_top #(
  parameter int unsigned FRAME_LENGTH = 12
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // byte stream in
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [7:0]                    in_tdata,   // [7:0] data_byte
  input  logic                          in_tuser,   // [0] frame_start
  // decision stream out
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [7:0]                    out_tdata,  // [0] accept, [7:1] zero
  // register port
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [fac_pkg::CfgAddrW-1:0]  cfg_paddr,
  input  logic [fac_pkg::CfgDataW-1:0]  cfg_pwdata,
  output logic [fac_pkg::CfgDataW-1:0]  cfg_prdata,
  output logic                          cfg_pready
);
  import fac_pkg::*;

  fac_cfg_t  cfg;
  fac_item_t in_item;
  fac_item_t s1_item;
  logic      s1_valid;
  logic      s1_take;
  logic      res_accept;

  assign in_item.data_byte   = in_tdata;
  assign in_item.frame_start = in_tuser;

  // node address and broadcast registers
  fac_cfg_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // input register, parts the upstream handshake from the tracker
  fac_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_item  (in_item),
    .s1_valid (s1_valid),
    .s1_take  (s1_take),
    .s1_item  (s1_item)
  );

  // frame tracker with result register; takes a beat whenever the result
  // slot is free or being drained
  fac_core #(
    .FRAME_LENGTH (FRAME_LENGTH)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .s1_valid   (s1_valid),
    .s1_take    (s1_take),
    .s1_item    (s1_item),
    .res_valid  (out_tvalid),
    .res_ready  (out_tready),
    .res_accept (res_accept)
  );

  assign out_tdata = {7'd0, res_accept};

endmodule

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for frame_address_checksum_filter_top: drives byte
// beats with random gaps, stalls the decision stream, predicts each frame
// decision from its own model of position, sum and captured address, and
// checks register writes by reading them back
// ----------------------------------------------------------------------------
module tb;
  import fac_pkg::*;

  localparam int FRAME_LEN   = 12;
  localparam int SETTLE      = 4;     // settle time after the last owed decision, to flush the pipeline
  localparam int IDLE_LIMIT  = 4000;  // cycles without any accepted beat

  // clock and reset
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // byte stream toward the block
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata  = 8'h00;   // [7:0] data_byte
  logic        in_tuser  = 1'b0;    // [0] frame_start

  // decision stream from the block
  logic        out_tvalid;
  logic        out_tready = 1'b1;
  logic [7:0]  out_tdata;           // [0] accept, [7:1] zero

  // register port
  logic                 cfg_psel    = 1'b0;
  logic                 cfg_penable = 1'b0;
  logic                 cfg_pwrite  = 1'b0;
  logic [CfgAddrW-1:0]  cfg_paddr   = '0;
  logic [CfgDataW-1:0]  cfg_pwdata  = '0;
  logic [CfgDataW-1:0]  cfg_prdata;
  logic                 cfg_pready;

  frame_address_checksum_filter_top #(
    .FRAME_LENGTH (FRAME_LEN)
  ) DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // frame filter model: node identity plus per-frame tracking state
  // --------------------------------------------------------------------------
  fac_cfg_t node_id = '{own_cluster_id: 8'h00, own_inner_number: 8'h00,
                        own_physical_address: 16'h0000,
                        broadcast_value: BcastResetVal};
  logic [7:0] frame_pos   = 8'h00;
  logic [7:0] byte_sum    = 8'h00;
  logic [7:0] addr_hi     = 8'h00;
  logic [7:0] addr_lo     = 8'h00;
  bit         lead_nonzero = 1'b0;

  // decisions still owed by the block, oldest first
  bit  decisions_due[$];
  int  errors     = 0;
  int  items_sent = 0;

  // idling knobs, changed per phase
  bit  in_gap_on    = 1'b1;
  bit  out_stall_on = 1'b1;

  // staging buffer for one frame
  logic [7:0] frame_buf [FRAME_LEN];

  // any of the four address forms that this node answers to
  function automatic bit address_hits();
    return (addr_hi == node_id.own_cluster_id && addr_lo == node_id.own_inner_number) ||
           (addr_hi == node_id.broadcast_value && addr_lo == node_id.broadcast_value) ||
           ({addr_hi, addr_lo} == node_id.own_physical_address) ||
           (addr_hi == node_id.own_cluster_id && addr_lo == node_id.broadcast_value);
  endfunction

  // advance the model by one accepted byte; a decision comes out on the last byte
  function automatic void filter_byte(input logic [7:0] b, input bit start,
                                      output bit decided, output bit accepted);
    logic [7:0] check;
    decided  = 1'b0;
    accepted = 1'b0;
    if (start) frame_pos = 8'h00;
    if (frame_pos >= FRAME_LEN - 1) begin
      // checksum byte: compared, not summed, and the position wraps
      check    = CheckBase - byte_sum;
      decided  = 1'b1;
      accepted = lead_nonzero && address_hits() && (check == b);
      frame_pos = 8'h00;
      byte_sum  = 8'h00;
    end else begin
      if (frame_pos == 0) begin
        byte_sum     = 8'h00;
        lead_nonzero = (b != 8'h00);
        addr_hi      = 8'h00;
        addr_lo      = 8'h00;
      end else if (frame_pos == 2) begin
        addr_hi = b;
      end else if (frame_pos == 3) begin
        addr_lo = b;
      end
      byte_sum  = byte_sum + b;
      frame_pos = frame_pos + 8'h01;
    end
  endfunction

  function automatic logic [31:0] node_reg(reg_idx_t idx);
    case (idx)
      REG_CLUSTER_ID: return {24'h0, node_id.own_cluster_id};
      REG_INNER_NUM:  return {24'h0, node_id.own_inner_number};
      REG_PHYS_ADDR:  return {16'h0, node_id.own_physical_address};
      default:        return {24'h0, node_id.broadcast_value};
    endcase
  endfunction

  // mostly short gaps, some long ones
  function automatic int pick_gap(bit enabled);
    int r;
    if (!enabled) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // body bytes lean toward the extremes now and then
  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8)  return 8'h00;
    if (r < 16) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  // build a frame with the given lead byte and address, checksum good or broken
  function automatic void fill_frame(logic [7:0] lead, logic [7:0] hi, logic [7:0] lo,
                                     bit good_sum);
    logic [7:0] sum;
    logic [7:0] check;
    sum = 8'h00;
    frame_buf[0] = lead;
    frame_buf[1] = pick_byte();
    frame_buf[2] = hi;
    frame_buf[3] = lo;
    for (int i = 4; i < FRAME_LEN - 1; i++) frame_buf[i] = pick_byte();
    for (int i = 0; i < FRAME_LEN - 1; i++) sum = sum + frame_buf[i];
    check = CheckBase - sum;
    frame_buf[FRAME_LEN-1] = good_sum ? check : check ^ 8'($urandom_range(1, 255));
  endfunction

  task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
    $display("mismatch %s: expected %0h got %0h at %0t", what, want, got, $realtime);
    errors++;
  endtask

  // --------------------------------------------------------------------------
  // byte beats: valid stays high across back-to-back beats, drops for a gap
  // --------------------------------------------------------------------------
  task automatic send_byte(logic [7:0] b, bit start);
    bit decided;
    bit accepted;
    int gap;
    in_tdata  <= b;
    in_tuser  <= start;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    items_sent++;
    filter_byte(b, start, decided, accepted);
    if (decided) decisions_due.push_back(accepted);
    gap = pick_gap(in_gap_on);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_frame(int count, bit flag);
    for (int i = 0; i < count; i++) send_byte(frame_buf[i], flag && (i == 0));
  endtask

  // sender holds off until every owed decision is out
  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (decisions_due.size() != 0);
  endtask

  // quiet block: nothing owed and the pipeline flushed
  task automatic drain_block();
    wait_for_results();
    repeat (SETTLE) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // register port: setup then access, then idle with psel low after each transfer
  // --------------------------------------------------------------------------
  task automatic apb_cycle(bit wr, reg_idx_t idx, logic [31:0] wdata,
                           output logic [31:0] rdata);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_register(reg_idx_t idx);
    logic [31:0] rdata;
    apb_cycle(1'b0, idx, 32'h0, rdata);
    if (rdata !== node_reg(idx)) report_mismatch({"readback ", idx.name()}, node_reg(idx), rdata);
  endtask

  task automatic set_register(reg_idx_t idx, logic [31:0] value);
    logic [31:0] rdata;
    apb_cycle(1'b1, idx, value, rdata);
    case (idx)
      REG_CLUSTER_ID: node_id.own_cluster_id       = value[7:0];
      REG_INNER_NUM:  node_id.own_inner_number     = value[7:0];
      REG_PHYS_ADDR:  node_id.own_physical_address = value[15:0];
      default:        node_id.broadcast_value      = value[7:0];
    endcase
    check_register(idx);
  endtask

  // --------------------------------------------------------------------------
  // decision stream: random backpressure, then compare each beat in order
  // --------------------------------------------------------------------------
  int stall_left = 0;
  always @(posedge clk) begin
    if (stall_left > 0) stall_left--;
    else if ($urandom_range(0, 3) == 0) stall_left = pick_gap(out_stall_on);
    out_tready <= (stall_left == 0);
  end

  always @(posedge clk) begin
    bit want;
    if (rst_n && out_tvalid && out_tready) begin
      if (decisions_due.size() == 0) begin
        report_mismatch("decision with none owed", 32'h0, {24'h0, out_tdata});
      end else begin
        want = decisions_due.pop_front();
        if (out_tdata[0] !== want)
          report_mismatch("accept", {31'h0, want}, {31'h0, out_tdata[0]});
        if (out_tdata[7:1] !== 7'h00)
          report_mismatch("tdata padding", 32'h0, {25'h0, out_tdata[7:1]});
      end
    end
  end

  // watchdog: any accepted beat on any port restarts the count
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_psel && cfg_penable && cfg_pready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no beat for %0d cycles", IDLE_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // registers come out of reset as zero, broadcast marker all ones
  task automatic test_reset_values();
    check_register(REG_CLUSTER_ID);
    check_register(REG_INNER_NUM);
    check_register(REG_PHYS_ADDR);
    check_register(REG_BCAST_VAL);
  endtask

  // resync on a start flag mid-frame, then a frame that follows with no flag
  task automatic test_directed_frames();
    // partial frame, abandoned after three bytes
    fill_frame(8'hFF, 8'h00, 8'h00, 1'b1);
    send_frame(3, 1'b1);
    // full frame matching own cluster and inner number (both zero after reset),
    // body bytes alternate between the extremes
    fill_frame(8'hFF, 8'h00, 8'h00, 1'b1);
    for (int i = 4; i < FRAME_LEN - 1; i++) frame_buf[i] = (i % 2 != 0) ? 8'hFF : 8'h00;
    begin
      logic [7:0] sum;
      sum = 8'h00;
      for (int i = 0; i < FRAME_LEN - 1; i++) sum = sum + frame_buf[i];
      frame_buf[FRAME_LEN-1] = CheckBase - sum;
    end
    send_frame(FRAME_LEN, 1'b1);
    // next frame rides on the position wrap: no start flag, zero lead byte,
    // full broadcast address and a good checksum, still rejected
    fill_frame(8'h00, 8'hFF, 8'hFF, 1'b1);
    send_frame(FRAME_LEN, 1'b0);
    drain_block();
  endtask

  // phases of random frames under a range of node identities
  task automatic test_random_traffic();
    logic [7:0]  cl, inn, bc, hi, lo, lead;
    logic [15:0] ph;
    int goal, frames, r;
    for (int phase = 0; phase < 6; phase++) begin
      drain_block();
      cl  = 8'($urandom);
      inn = 8'($urandom);
      ph  = 16'($urandom);
      bc  = 8'($urandom);
      case (phase)
        0: begin cl = 8'h00; inn = 8'h00; ph = 16'h0000; bc = 8'h00; end
        1: begin cl = 8'hFF; inn = 8'hFF; ph = 16'hFFFF; bc = 8'hFF; end
        3: bc = cl;              // broadcast marker equal to own cluster
        4: ph = {cl, inn};       // physical address aliases cluster/inner
        default: ;
      endcase
      // upper bits of each write are junk that the block must drop
      set_register(REG_CLUSTER_ID, {24'($urandom), cl});
      set_register(REG_INNER_NUM,  {24'($urandom), inn});
      set_register(REG_PHYS_ADDR,  {16'($urandom), ph});
      set_register(REG_BCAST_VAL,  {24'($urandom), bc});
      // every third phase runs with no idling at all
      in_gap_on    = (phase % 3 != 1);
      out_stall_on = (phase % 3 != 1);
      goal   = items_sent + 255;
      frames = 0;
      while (items_sent < goal) begin
        case ($urandom_range(0, 5))
          0: begin hi = node_id.own_cluster_id; lo = node_id.own_inner_number; end
          1: begin hi = node_id.broadcast_value; lo = node_id.broadcast_value; end
          2: {hi, lo} = node_id.own_physical_address;
          3: begin hi = node_id.own_cluster_id; lo = node_id.broadcast_value; end
          4: begin hi = node_id.own_cluster_id;
                   lo = node_id.own_inner_number ^ 8'(1 << $urandom_range(0, 7)); end
          default: begin hi = 8'($urandom); lo = 8'($urandom); end
        endcase
        lead = ($urandom_range(0, 9) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
        fill_frame(lead, hi, lo, $urandom_range(0, 4) != 0);
        r = $urandom_range(0, 99);
        if (r < 80) begin
          // well-formed frame, usually flagged, sometimes relying on the wrap
          send_frame(FRAME_LEN, $urandom_range(0, 6) != 0);
        end else if (r < 90) begin
          // truncated frame, the next flagged byte drops it
          send_frame($urandom_range(1, FRAME_LEN - 1), 1'b1);
        end else begin
          // loose bytes with stray start flags
          for (int k = $urandom_range(1, 5); k > 0; k--)
            send_byte(pick_byte(), $urandom_range(0, 3) == 0);
        end
        frames++;
        if (frames == 10 || $urandom_range(0, 39) == 0) wait_for_results();
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_values();
    test_directed_frames();
    test_random_traffic();
    drain_block();
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### files.f
rtl/fac_pkg.sv
rtl/fac_cfg_regs.sv
rtl/fac_in_stage.sv
rtl/fac_core.sv
rtl/frame_address_checksum_filter_top.sv
tb/sv/tb.sv
